### rtl/csr_spmv_pkg.sv
// shared types and constants for the csr sparse matrix-vector block
`default_nettype none

package csr_spmv_pkg;

  // source vector store
  localparam int SOURCE_DEPTH = 1024;
  localparam int SRC_AW       = $clog2(SOURCE_DEPTH);

  // rows per pass
  localparam int ROW_LIMIT = 1024;
  localparam int ROW_W     = 10;
  localparam int RCNT_W    = 11;

  // decoupling queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // data widths
  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int WIDE_W = 98;

  // input operation codes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NZ    = 2'd1,
    OP_EMPTY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_ROWS  = 2'd2,
    CFG_SPARE = 2'd3
  } cfg_idx_t;

  // configuration register set
  typedef struct packed {
    logic signed [DATA_W-1:0] alpha;
    logic signed [DATA_W-1:0] beta;
    logic [RCNT_W-1:0]        row_count;
  } cfg_regs_t;

  // one decoded work item handed from front to back
  typedef struct packed {
    logic                     empty_row;
    logic                     eor;
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] src;
    logic signed [DATA_W-1:0] old;
  } work_t;

endpackage

`default_nettype wire

### rtl/csr_spmv_front.sv
// front end: accepts beats, owns the source store, forwards row work
`default_nettype none

module csr_spmv_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  output logic                                    in_full,
  input  wire logic [1:0]                         in_operation,
  input  wire logic [csr_spmv_pkg::SRC_AW-1:0]    in_index,
  input  wire logic signed [csr_spmv_pkg::DATA_W-1:0] in_value,
  input  wire logic                               in_end_of_row,
  input  wire logic signed [csr_spmv_pkg::DATA_W-1:0] in_old_result,
  output logic                                    q_push,
  output csr_spmv_pkg::work_t                     q_wdata,
  input  wire logic                               q_full
);
  import csr_spmv_pkg::*;

  logic [DATA_W-1:0] src_mem [SOURCE_DEPTH];

  op_t                      op;
  logic                     accept;
  logic                     is_work;
  logic                     f_valid_r;
  logic                     f_valid_nxt;
  logic                     f_empty_r;
  logic                     f_eor_r;
  logic signed [DATA_W-1:0] f_weight_r;
  logic signed [DATA_W-1:0] f_old_r;
  logic [DATA_W-1:0]        f_src_r;

  // classify the incoming beat
  assign op      = op_t'(in_operation);
  assign is_work = (op inside {OP_NZ, OP_EMPTY});
  assign in_full = f_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = f_valid_r && !q_full;

  // source store: load writes, nonzero entry reads
  always_ff @(posedge clk) begin
    if (accept && (op == OP_LOAD)) begin
      src_mem[in_index] <= in_value;
    end
    if (accept && (op == OP_NZ)) begin
      f_src_r <= src_mem[in_index];
    end
  end

  // holding stage valid
  always_comb begin
    f_valid_nxt = f_valid_r;
    if (q_push) begin
      f_valid_nxt = 1'b0;
    end
    if (accept) begin
      f_valid_nxt = is_work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  // holding stage payload
  always_ff @(posedge clk) begin
    if (accept && is_work) begin
      f_empty_r  <= (op == OP_EMPTY);
      f_eor_r    <= in_end_of_row;
      f_weight_r <= in_value;
      f_old_r    <= in_old_result;
    end
  end

  assign q_wdata = '{empty_row: f_empty_r,
                     eor:       f_eor_r,
                     weight:    f_weight_r,
                     src:       f_src_r,
                     old:       f_old_r};

endmodule

`default_nettype wire

### rtl/csr_spmv_fifo.sv
// short queue of decoded work between front and back
`default_nettype none

module csr_spmv_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire csr_spmv_pkg::work_t  wdata,
  output logic                      full,
  input  wire logic                 pop,
  output csr_spmv_pkg::work_t       rdata,
  output logic                      empty
);
  import csr_spmv_pkg::*;

  work_t           slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/csr_spmv_back.sv
// back end: multiply-accumulate, row finish, row counter and result register
`default_nettype none

module csr_spmv_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire csr_spmv_pkg::cfg_regs_t              cfg,
  input  wire csr_spmv_pkg::work_t                  q_rdata,
  input  wire logic                                 q_empty,
  output logic                                      q_pop,
  output logic                                      out_empty,
  input  wire logic                                 out_pop,
  output logic signed [csr_spmv_pkg::DATA_W-1:0]    out_row_value,
  output logic [csr_spmv_pkg::ROW_W-1:0]            out_row_number,
  output logic                                      out_pass_done
);
  import csr_spmv_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_PROD = 8'b0000_0010,
    ST_ACC  = 8'b0000_0100,
    ST_BETA = 8'b0000_1000,
    ST_LO   = 8'b0001_0000,
    ST_HI   = 8'b0010_0000,
    ST_SUM  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t                   state_r;
  state_t                   state_nxt;
  work_t                    ent_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  sum_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [WIDE_W-1:0] wide_r;
  logic [ROW_W-1:0]         row_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [ROW_W-1:0]         out_row_r;
  logic                     out_done_r;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  term;
  logic [ACC_W:0]           acc_sum;
  logic signed [ACC_W-1:0]  acc_new;
  logic signed [DATA_W-1:0] fin_value;
  logic [RCNT_W-1:0]        eff_rows;
  logic                     last_row;
  logic                     out_load;

  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_pop);

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_PROD: begin
        mul_a = MUL_W'(ent_r.weight);
        mul_b = MUL_W'(ent_r.src);
      end
      ST_BETA: begin
        mul_a = MUL_W'(cfg.beta);
        mul_b = MUL_W'(ent_r.old);
      end
      ST_LO: begin
        mul_a = $signed({1'b0, sum_r[31:0]});
        mul_b = MUL_W'(cfg.alpha);
      end
      ST_HI: begin
        mul_a = MUL_W'($signed(sum_r[63:32]));
        mul_b = MUL_W'(cfg.alpha);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // floored product added to the row sum, saturating at 64 bits
  assign term    = {{16{prod_r[63]}}, prod_r[63:16]};
  assign acc_sum = {acc_r[ACC_W-1], acc_r} + {term[ACC_W-1], term};
  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
  end

  // floor by 2^16 then saturate to 32 bits
  always_comb begin
    if (!wide_r[WIDE_W-1] && (|wide_r[WIDE_W-2:47])) begin
      fin_value = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (wide_r[WIDE_W-1] && !(&wide_r[WIDE_W-2:47])) begin
      fin_value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      fin_value = wide_r[47:16];
    end
  end

  // effective rows per pass and last-row flag
  always_comb begin
    if (cfg.row_count == '0) begin
      eff_rows = RCNT_W'(1);
    end else if (cfg.row_count > RCNT_W'(ROW_LIMIT)) begin
      eff_rows = RCNT_W'(ROW_LIMIT);
    end else begin
      eff_rows = cfg.row_count;
    end
  end
  assign last_row = ({1'b0, row_r} + RCNT_W'(1)) >= eff_rows;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_rdata.empty_row ? ST_BETA : ST_PROD;
        end
      end
      ST_PROD: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ent_r.eor ? ST_BETA : ST_IDLE;
      ST_BETA: state_nxt = ST_LO;
      ST_LO:   state_nxt = ST_HI;
      ST_HI:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_rdata.empty_row) begin
        acc_r <= '0;
      end else if (state_r == ST_ACC) begin
        acc_r <= ent_r.eor ? '0 : acc_new;
      end
      if (out_load) begin
        row_r       <= last_row ? '0 : row_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (q_pop) begin
      ent_r <= q_rdata;
      if (q_rdata.empty_row) begin
        sum_r <= '0;
      end
    end
    if ((state_r == ST_ACC) && ent_r.eor) begin
      sum_r <= acc_new;
    end
    case (state_r)
      ST_LO:   wide_r <= {{(WIDE_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
      ST_HI:   wide_r <= wide_r + {{(WIDE_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
      ST_SUM:  wide_r <= wide_r + {prod_r, 32'b0};
      default: wide_r <= wide_r;
    endcase
    if (out_load) begin
      out_value_r <= fin_value;
      out_row_r   <= row_r;
      out_done_r  <= last_row;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_row_value  = out_value_r;
  assign out_row_number = out_row_r;
  assign out_pass_done  = out_done_r;

endmodule

`default_nettype wire

### rtl/csr_sparse_matrix_vector_axpby.sv
// top level of the csr sparse matrix-vector block: dst = alpha*A*src + beta*dst
//
// input channel: a beat is taken when in_push is high and in_full is low.
//   operation 0 loads a source element, 1 is a nonzero entry (end_of_row marks
//   the last of its row and carries old_result), 2 is an empty row, 3 is dropped.
// result channel: while out_empty is low the oldest result sits on out_*;
//   it is taken when out_pop is high. one result per finished row.
// config channel: cfg_ready is always high; cfg_index 0 alpha, 1 beta,
//   2 row count. write only while no row work is in flight.
// throughput: loads and dropped beats go at one per cycle while in_full is low. the
//   back end's single shared 33x33 multiplier sets the rest: it takes one item from
//   the queue at a time; a nonzero entry runs the product and accumulate states.
// path: a row-closing entry goes on through the beta, low, high, sum and output
//   states; an empty row starts at the beta state.
// reset: synchronous, active low; clears the row sum, row counter, queue and
//   result valid flag, and sets alpha to 1.0, beta to 0 and row count to 1.
//   the source store is not cleared.
// stall: a result waiting on out_pop holds the back end after its next row;
//   the 4-deep work queue and the front stage keep taking input until full.
`default_nettype none

module csr_sparse_matrix_vector_axpby (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_push,
  output logic                                        in_full,
  input  wire logic [1:0]                             in_operation,
  input  wire logic [csr_spmv_pkg::SRC_AW-1:0]        in_index,
  input  wire logic signed [csr_spmv_pkg::DATA_W-1:0] in_value,
  input  wire logic                                   in_end_of_row,
  input  wire logic signed [csr_spmv_pkg::DATA_W-1:0] in_old_result,
  output logic                                        out_empty,
  input  wire logic                                   out_pop,
  output logic signed [csr_spmv_pkg::DATA_W-1:0]      out_row_value,
  output logic [csr_spmv_pkg::ROW_W-1:0]              out_row_number,
  output logic                                        out_pass_done,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [1:0]                             cfg_index,
  input  wire logic [csr_spmv_pkg::DATA_W-1:0]        cfg_data
);
  import csr_spmv_pkg::*;

  cfg_regs_t cfg_r;
  cfg_idx_t  cfg_sel;
  work_t     q_wdata;
  work_t     q_rdata;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_sel   = cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha     <= DATA_W'(65536);
      cfg_r.beta      <= '0;
      cfg_r.row_count <= RCNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_sel)
        CFG_ALPHA: cfg_r.alpha     <= cfg_data;
        CFG_BETA:  cfg_r.beta      <= cfg_data;
        CFG_ROWS:  cfg_r.row_count <= cfg_data[RCNT_W-1:0];
        default:   cfg_r           <= cfg_r;
      endcase
    end
  end

  csr_spmv_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_operation  (in_operation),
    .in_index      (in_index),
    .in_value      (in_value),
    .in_end_of_row (in_end_of_row),
    .in_old_result (in_old_result),
    .q_push        (q_push),
    .q_wdata       (q_wdata),
    .q_full        (q_full)
  );

  csr_spmv_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  csr_spmv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_rdata        (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_row_value  (out_row_value),
    .out_row_number (out_row_number),
    .out_pass_done  (out_pass_done)
  );

  // front never pushes work into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("work pushed into full queue");

  // back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !q_pop)
    else $error("work popped from empty queue");

  // no result is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result visible after reset");

endmodule

`default_nettype wire
